// ===== rtl/core/rpa_pkg.sv =====
// Shared types, codes and constants for the relay autotuner core.
`default_nettype none
package rpa_pkg;

  localparam int TEMP_WIDTH_DEF       = 16;
  localparam int GAIN_FRAC_BITS_DEF   = 16;
  localparam int MIN_CROSS_GAP_MS_DEF = 500;

  localparam int WORK_FRAC     = 40;
  localparam int MIN_PERIOD_MS = 500;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [14:0] HALF_DRIVE  = 15'd12800;
  localparam logic [14:0] FULL_DRIVE  = 15'd25600;
  localparam logic [31:0] PI_SCALED   = 32'd31415926;
  localparam logic [31:0] RELAY_SCALE = 32'd20000000;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TLIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RULE     = 3'd6;

  localparam logic [1:0] OP_KU = 2'd0;
  localparam logic [1:0] OP_KP = 2'd1;
  localparam logic [1:0] OP_KI = 2'd2;
  localparam logic [1:0] OP_KD = 2'd3;

  typedef struct packed {
    logic       take;
    logic       calc_load;
    logic       emit;
    logic [1:0] op;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic fin_ok;
    logic md_done;
  } status_t;

  // Rule coefficients: p num, p den, i num*1000, i den, d num, d den*1000
  function automatic logic [31:0] rule_coef(input logic rule, input logic [2:0] idx);
    logic [31:0] v;
    v = 32'd1;
    if (!rule) begin
      case (idx)
        3'd0: v = 32'd6;
        3'd1: v = 32'd10;
        3'd2: v = 32'd12000;
        3'd3: v = 32'd10;
        3'd4: v = 32'd75;
        3'd5: v = 32'd1000000;
        default: v = 32'd1;
      endcase
    end else begin
      case (idx)
        3'd0: v = 32'd454;
        3'd1: v = 32'd1000;
        3'd2: v = 32'd454000;
        3'd3: v = 32'd2200;
        3'd4: v = 32'd454;
        3'd5: v = 32'd6300000;
        default: v = 32'd1;
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rpa_if.sv =====
// Input and output stream interfaces of the relay autotuner.
`default_nettype none
interface rpa_in_if #(parameter int TEMP_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [TEMP_WIDTH-1:0] temperature;
  logic [31:0]                  now_ms;
  modport source (output valid, command, temperature, now_ms, input ready);
  modport sink (input valid, command, temperature, now_ms, output ready);
endinterface

interface rpa_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] drive;
  logic        running;
  logic        finished;
  logic        tuned_ok;
  logic [31:0] gain_p_out;
  logic [31:0] gain_i_out;
  logic [31:0] gain_d_out;
  modport source (output valid, drive, running, finished, tuned_ok,
                  gain_p_out, gain_i_out, gain_d_out, input ready);
  modport sink (input valid, drive, running, finished, tuned_ok,
                gain_p_out, gain_i_out, gain_d_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rpa_muldiv.sv =====
// Bit-serial floor(a*b/d) unit with saturation at 2^64-1.
`default_nettype none
module rpa_muldiv import rpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] d,
  output logic             done,
  output logic [63:0]      q
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_CHK  = 2'd2;
  localparam logic [1:0] P_DIV  = 2'd3;

  logic [1:0]   phase;
  logic [5:0]   cnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  dv;
  logic [127:0] p;
  logic [64:0]  r2;
  logic [64:0]  r2_sub;

  assign r2     = {p[127:64], p[63]};
  assign r2_sub = r2 - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            ma    <= a;
            mb    <= b;
            dv    <= d;
            p     <= '0;
            cnt   <= '0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          p   <= {p[126:0], 1'b0} + {64'd0, (mb[63] ? ma : 64'd0)};
          mb  <= {mb[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) phase <= P_CHK;
        end
        P_CHK: begin
          // divide by zero, or quotient would not fit in 64 bits
          if (dv == 64'd0 || p[127:64] >= dv) begin
            q     <= '1;
            done  <= 1'b1;
            phase <= P_IDLE;
          end else begin
            cnt   <= '0;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          if (!r2_sub[64]) begin
            p <= {r2_sub[63:0], p[62:0], 1'b0};
            q <= {q[62:0], 1'b1};
          end else begin
            p <= {r2[63:0], p[62:0], 1'b0};
            q <= {q[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rpa_ctrl.sv =====
// Sequencer: input transfer, gain computation steps and output load.
`default_nettype none
module rpa_ctrl import rpa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] op;
  logic       emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd.take      = 1'b0;
    cmd.calc_load = 1'b0;
    cmd.emit      = 1'b0;
    cmd.op        = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = (status.fin && status.fin_ok) ? S_LOAD : S_EMIT;
      S_LOAD: begin
        cmd.calc_load = 1'b1;
        state_next    = S_CALC;
      end
      S_CALC: begin
        if (status.md_done) state_next = (op == OP_KD) ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_KU;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CHECK) op <= OP_KU;
      else if (state == S_CALC && status.md_done) op <= op + 2'd1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rpa_datapath.sv =====
// Relay, crossing and peak tracking, gain operands and result registers.
`default_nettype none
module rpa_datapath import rpa_pkg::*; #(
  parameter int TEMP_WIDTH       = TEMP_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
  parameter int MIN_CROSS_GAP_MS = MIN_CROSS_GAP_MS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  output status_t                           status,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic [1:0]                   command,
  input  wire logic signed [TEMP_WIDTH-1:0] temperature,
  input  wire logic [31:0]                  now_ms,
  output logic [14:0]                       drive,
  output logic                              running,
  output logic                              finished,
  output logic                              tuned_ok,
  output logic [31:0]                       gain_p_out,
  output logic [31:0]                       gain_i_out,
  output logic [31:0]                       gain_d_out
);

  localparam int CW    = TEMP_WIDTH + 2;
  localparam int SHIFT = WORK_FRAC - GAIN_FRAC_BITS;
  localparam logic signed [TEMP_WIDTH-1:0] T_MIN = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
  localparam logic signed [TEMP_WIDTH-1:0] T_MAX = {1'b0, {(TEMP_WIDTH-1){1'b1}}};

  logic signed [TEMP_WIDTH-1:0] setpoint;
  logic [11:0] hyst;
  logic [13:0] ramp;
  logic [31:0] tlim;
  logic [31:0] tsettle;
  logic [7:0]  creq;
  logic        rule;

  logic active, done_f, success, relay_high, cross_valid, fin;
  logic [31:0] start_time, last_cross, period_total;
  logic [7:0]  cycle_count;
  logic signed [TEMP_WIDTH-1:0] peak_high, peak_low;
  logic [14:0] drive_level, drive_res;
  logic [31:0] gain [3];
  logic [63:0] ku;

  logic signed [CW-1:0] t_ext, sp_hi, sp_lo;
  logic [15:0] up_sum;
  logic [14:0] drive_up, drive_dn, drive_new;
  logic [31:0] elapsed, gap;
  logic [32:0] psum;
  logic        cross_up, cross_dn, counted, settled, finalize;
  logic [7:0]  cc_after;
  logic [31:0] period_after;
  logic signed [TEMP_WIDTH:0] diff;
  logic [16:0] min_t;
  logic [63:0] md_a, md_b, md_d, md_q;
  logic        md_done;
  logic [64:0] g_round;
  logic [31:0] g_val;

  assign t_ext  = CW'(temperature);
  assign sp_hi  = CW'(setpoint) + CW'($signed({1'b0, hyst}));
  assign sp_lo  = CW'(setpoint) - CW'($signed({1'b0, hyst}));
  assign up_sum = {1'b0, HALF_DRIVE} + {2'b00, ramp};
  assign drive_up = (up_sum > {1'b0, FULL_DRIVE}) ? FULL_DRIVE : up_sum[14:0];
  assign drive_dn = ({1'b0, ramp} > HALF_DRIVE) ? 15'd0 : HALF_DRIVE - {1'b0, ramp};

  assign elapsed  = now_ms - start_time;
  assign gap      = now_ms - last_cross;
  assign psum     = {1'b0, period_total} + {1'b0, gap};
  assign cross_up = relay_high && (t_ext > sp_hi);
  assign cross_dn = !relay_high && (t_ext < sp_lo);
  assign counted  = cross_up && cross_valid && (gap > 32'(MIN_CROSS_GAP_MS));
  assign cc_after = (counted && cycle_count != 8'hFF) ? cycle_count + 8'd1 : cycle_count;
  assign period_after = !counted ? period_total : (psum[32] ? 32'hFFFF_FFFF : psum[31:0]);
  assign settled  = elapsed > tsettle;
  assign finalize = cc_after >= creq;
  assign drive_new = cross_up ? drive_dn : (cross_dn ? drive_up : drive_level);

  // success test on the stored run state
  assign diff  = (TEMP_WIDTH+1)'(peak_high) - (TEMP_WIDTH+1)'(peak_low);
  assign min_t = 17'(MIN_PERIOD_MS) * {9'd0, cycle_count};
  assign status.fin     = fin;
  assign status.fin_ok  = (diff > (TEMP_WIDTH+1)'(6)) && (cycle_count != 8'd0) &&
                          (period_total > {15'd0, min_t});
  assign status.md_done = md_done;

  always_comb begin
    md_a = ku;
    md_b = 64'd1;
    md_d = 64'd1;
    case (cmd.op)
      OP_KU: begin
        md_a = 64'(ramp) * 64'(RELAY_SCALE);
        md_b = 64'd1 << WORK_FRAC;
        md_d = 64'(PI_SCALED) * 64'(diff[TEMP_WIDTH-1:0]);
      end
      OP_KP: begin
        md_b = 64'(rule_coef(rule, 3'd0));
        md_d = 64'(rule_coef(rule, 3'd1));
      end
      OP_KI: begin
        md_b = 64'(rule_coef(rule, 3'd2)) * 64'(cycle_count);
        md_d = 64'(rule_coef(rule, 3'd3)) * 64'(period_total);
      end
      OP_KD: begin
        md_b = 64'(rule_coef(rule, 3'd4)) * 64'(period_total);
        md_d = 64'(rule_coef(rule, 3'd5)) * 64'(cycle_count);
      end
      default: md_a = ku;
    endcase
  end

  rpa_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.calc_load),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  // round to nearest at the output fraction width, then saturate
  assign g_round = {1'b0, md_q >> SHIFT} + 65'(md_q[SHIFT-1]);
  assign g_val   = (g_round[64:32] != '0) ? 32'hFFFF_FFFF : g_round[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= '0;
      hyst         <= 12'd32;
      ramp         <= 14'd5120;
      tlim         <= 32'd600000;
      tsettle      <= 32'd30000;
      creq         <= 8'd3;
      rule         <= 1'b0;
      active       <= 1'b0;
      done_f       <= 1'b0;
      success      <= 1'b0;
      relay_high   <= 1'b1;
      cross_valid  <= 1'b0;
      fin          <= 1'b0;
      start_time   <= '0;
      last_cross   <= '0;
      period_total <= '0;
      cycle_count  <= '0;
      peak_high    <= T_MIN;
      peak_low     <= T_MAX;
      drive_level  <= '0;
      gain[0]      <= '0;
      gain[1]      <= '0;
      gain[2]      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SETPOINT: setpoint <= cfg_wdata[TEMP_WIDTH-1:0];
          REG_HYST:     hyst     <= cfg_wdata[11:0];
          REG_AMP:      ramp     <= cfg_wdata[13:0];
          REG_TLIMIT:   tlim     <= cfg_wdata;
          REG_SETTLE:   tsettle  <= cfg_wdata;
          REG_CYCLES:   creq     <= cfg_wdata[7:0];
          REG_RULE:     rule     <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        fin       <= 1'b0;
        drive_res <= '0;
        case (command)
          CMD_BEGIN: begin
            active       <= 1'b1;
            done_f       <= 1'b0;
            success      <= 1'b0;
            gain[0]      <= '0;
            gain[1]      <= '0;
            gain[2]      <= '0;
            start_time   <= now_ms;
            relay_high   <= 1'b1;
            drive_level  <= drive_up;
            peak_high    <= T_MIN;
            peak_low     <= T_MAX;
            cross_valid  <= 1'b0;
            last_cross   <= '0;
            period_total <= '0;
            cycle_count  <= '0;
            drive_res    <= drive_up;
          end
          CMD_CANCEL: begin
            active  <= 1'b0;
            done_f  <= 1'b1;
            success <= 1'b0;
            gain[0] <= '0;
            gain[1] <= '0;
            gain[2] <= '0;
          end
          CMD_NOP: drive_res <= active ? drive_level : 15'd0;
          default: begin
            if (active) begin
              if (elapsed > tlim) begin
                active  <= 1'b0;
                done_f  <= 1'b1;
                success <= 1'b0;
                gain[0] <= '0;
                gain[1] <= '0;
                gain[2] <= '0;
              end else begin
                if (cross_up) begin
                  relay_high  <= 1'b0;
                  last_cross  <= now_ms;
                  cross_valid <= 1'b1;
                end else if (cross_dn) begin
                  relay_high <= 1'b1;
                end
                drive_level  <= drive_new;
                period_total <= period_after;
                cycle_count  <= cc_after;
                if (settled) begin
                  if (temperature > peak_high) peak_high <= temperature;
                  if (temperature < peak_low) peak_low <= temperature;
                end
                if (finalize) begin
                  fin     <= 1'b1;
                  active  <= 1'b0;
                  done_f  <= 1'b1;
                  success <= 1'b0;
                  gain[0] <= '0;
                  gain[1] <= '0;
                  gain[2] <= '0;
                end
                drive_res <= drive_new;
              end
            end
          end
        endcase
      end
      if (md_done) begin
        case (cmd.op)
          OP_KU: ku <= md_q;
          OP_KP: gain[0] <= g_val;
          OP_KI: gain[1] <= g_val;
          OP_KD: begin
            gain[2] <= g_val;
            success <= 1'b1;
          end
          default: ku <= md_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      drive      <= drive_res;
      running    <= active;
      finished   <= done_f;
      tuned_ok   <= success;
      gain_p_out <= gain[0];
      gain_i_out <= gain[1];
      gain_d_out <= gain[2];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/relay_pid_autotuner_core.sv =====
// Top level of the relay-feedback PID autotuner.
// Each input transfer (sample, begin, cancel, nop) yields one result transfer.
// An item that does not complete a run passes through accept, check and output
// load, and input ready returns after the output load. The sample that completes
// a successful run also runs four floor(a*b/d) steps on the shared bit-serial
// multiply/divide unit, each made of load, multiply, range check, divide and
// handing back the quotient; a step whose quotient saturates ends after the
// range check. The result waits in an output register, so a new item is taken
// while the previous result is still pending downstream.
`default_nettype none
module relay_pid_autotuner_core import rpa_pkg::*; #(
  parameter int TEMP_WIDTH       = TEMP_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
  parameter int MIN_CROSS_GAP_MS = MIN_CROSS_GAP_MS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rpa_in_if.sink                     in_ch,
  rpa_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rpa_datapath #(
    .TEMP_WIDTH       (TEMP_WIDTH),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
    .MIN_CROSS_GAP_MS (MIN_CROSS_GAP_MS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .command     (in_ch.command),
    .temperature (in_ch.temperature),
    .now_ms      (in_ch.now_ms),
    .drive       (out_ch.drive),
    .running     (out_ch.running),
    .finished    (out_ch.finished),
    .tuned_ok    (out_ch.tuned_ok),
    .gain_p_out  (out_ch.gain_p_out),
    .gain_i_out  (out_ch.gain_i_out),
    .gain_d_out  (out_ch.gain_d_out)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("output load did not raise valid");

  a_tuned_ended: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.tuned_ok) |-> (out_ch.finished && !out_ch.running))
    else $error("tuned result while run still active");

  a_no_calc_on_input: assert property (@(posedge clk) disable iff (rst)
    cmd.calc_load |-> !in_ready)
    else $error("gain step started while input open");

endmodule
`default_nettype wire

// ===== tb/sv/relay_pid_autotuner_core_tb.sv =====
// Self-checking testbench for the relay-feedback PID autotuner core.
module relay_pid_autotuner_core_tb;
  import rpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [14:0] drive;
    logic        running;
    logic        finished;
    logic        tuned_ok;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
  } tune_res_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] temp;
    logic [31:0]        t_ms;
    bit                 has_exp;
    tune_res_t          exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpa_in_if #(.TEMP_WIDTH(16)) in_ch ();
  rpa_out_if out_ch ();

  relay_pid_autotuner_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // tuner state mirror
  longint       sp_cfg;
  int unsigned  hyst_cfg, amp_cfg, creq_cfg;
  logic [31:0]  tlim_cfg, settle_cfg;
  bit           rule_cfg;
  bit           act_f, done_f, ok_f, relay_hi, cross_ok;
  logic [31:0]  t_start, t_last_cross, period_sum;
  int unsigned  cyc_cnt;
  longint       pk_hi, pk_lo;
  logic [14:0]  drv_lvl;
  logic [31:0]  gain_q [3];

  // Ziegler-Nichols row 0, Tyreus-Luyben row 1
  const logic [63:0] P_NUM [2] = '{64'd6, 64'd454};
  const logic [63:0] P_DEN [2] = '{64'd10, 64'd1000};
  const logic [63:0] I_NUM [2] = '{64'd12, 64'd454};
  const logic [63:0] I_DEN [2] = '{64'd10, 64'd2200};
  const logic [63:0] D_NUM [2] = '{64'd75, 64'd454};
  const logic [63:0] D_DEN [2] = '{64'd1000, 64'd6300};

  tune_res_t expected_q [$];
  int  n_err = 0, n_results = 0, n_items = 0, n_ok_runs = 0, n_stall = 0;
  int  src_idle_pct = 0, rx_idle_pct = 0, hold_cnt = 0;

  function automatic logic [63:0] mul_div64(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] p, q;
    p = {64'd0, a} * {64'd0, b};
    if (d == 0 || p[127:64] >= d) return '1;
    q = p / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [31:0] q40_to_gain(logic [63:0] q);
    logic [40:0] r;
    r = {1'b0, q[63:40-GAIN_FRAC_BITS_DEF]} + 41'(q[39-GAIN_FRAC_BITS_DEF]);
    return (r > 41'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  task automatic clear_gains();
    gain_q[0] = 0; gain_q[1] = 0; gain_q[2] = 0;
    ok_f = 0;
  endtask

  function automatic logic [14:0] clamp_drive(longint v);
    if (v < 0) return 0;
    if (v > 25600) return 15'd25600;
    return v[14:0];
  endfunction

  task automatic compute_gains();
    longint diff;
    logic [63:0] c, tt, ku;
    diff = pk_hi - pk_lo;
    c = cyc_cnt;
    tt = period_sum;
    clear_gains();
    if (!(diff * 5 > 32 && c > 0 && tt > 64'd500 * c)) return;
    ku = mul_div64(64'd2 * amp_cfg * 64'd10000000, 64'd1 << 40, 64'd31415926 * diff);
    gain_q[0] = q40_to_gain(mul_div64(ku, P_NUM[rule_cfg], P_DEN[rule_cfg]));
    gain_q[1] = q40_to_gain(mul_div64(ku, I_NUM[rule_cfg] * 1000 * c, I_DEN[rule_cfg] * tt));
    gain_q[2] = q40_to_gain(mul_div64(ku, D_NUM[rule_cfg] * tt, D_DEN[rule_cfg] * 1000 * c));
    ok_f = 1;
    n_ok_runs++;
  endtask

  task automatic tuner_reset();
    sp_cfg = 0; hyst_cfg = 32; amp_cfg = 5120; tlim_cfg = 600000; settle_cfg = 30000;
    creq_cfg = 3; rule_cfg = 0;
    act_f = 0; done_f = 0; ok_f = 0; cross_ok = 0; relay_hi = 1;
    t_start = 0; t_last_cross = 0; period_sum = 0; cyc_cnt = 0;
    pk_hi = -32768; pk_lo = 32767; drv_lvl = 0;
    gain_q[0] = 0; gain_q[1] = 0; gain_q[2] = 0;
  endtask

  task automatic tuner_step(input logic [1:0] cmd, input logic signed [15:0] temp,
                            input logic [31:0] t_ms, output tune_res_t r);
    logic [14:0] drv;
    logic [31:0] elapsed, gap;
    logic [32:0] s;
    longint tv;
    drv = 0;
    tv = temp;
    if (cmd == CMD_BEGIN) begin
      act_f = 1; done_f = 0; clear_gains();
      t_start = t_ms; relay_hi = 1;
      drv_lvl = clamp_drive(12800 + longint'(amp_cfg));
      pk_hi = -32768; pk_lo = 32767;
      cross_ok = 0; t_last_cross = 0; period_sum = 0; cyc_cnt = 0;
      drv = drv_lvl;
    end else if (cmd == CMD_CANCEL) begin
      act_f = 0; done_f = 1; clear_gains();
    end else if (cmd == CMD_NOP) begin
      drv = act_f ? drv_lvl : 15'd0;
    end else if (act_f) begin
      elapsed = t_ms - t_start;
      if (elapsed > tlim_cfg) begin
        act_f = 0; done_f = 1; clear_gains();
      end else begin
        if (relay_hi) begin
          if (tv > sp_cfg + longint'(hyst_cfg)) begin
            gap = t_ms - t_last_cross;
            relay_hi = 0;
            drv_lvl = clamp_drive(12800 - longint'(amp_cfg));
            if (cross_ok && gap > MIN_CROSS_GAP_MS_DEF) begin
              s = {1'b0, period_sum} + gap;
              period_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
              if (cyc_cnt < 255) cyc_cnt++;
            end
            t_last_cross = t_ms;
            cross_ok = 1;
          end
        end else if (tv < sp_cfg - longint'(hyst_cfg)) begin
          relay_hi = 1;
          drv_lvl = clamp_drive(12800 + longint'(amp_cfg));
        end
        if (elapsed > settle_cfg) begin
          if (tv > pk_hi) pk_hi = tv;
          if (tv < pk_lo) pk_lo = tv;
        end
        if (cyc_cnt >= creq_cfg) begin
          compute_gains();
          act_f = 0; done_f = 1;
        end
        drv = drv_lvl;
      end
    end
    r = '{drv, act_f, done_f, ok_f, gain_q[0], gain_q[1], gain_q[2]};
  endtask

  // sender: one transfer, optional idle gap in front
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] temp,
                           input logic [31:0] t_ms, input bit has_exp, input tune_res_t exp_res);
    tune_res_t r;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.temperature <= temp;
    in_ch.now_ms <= t_ms;
    do @(posedge clk); while (!in_ch.ready);
    tuner_step(cmd, temp, t_ms, r);
    expected_q.push_back(has_exp ? exp_res : r);
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT: sp_cfg = longint'(signed'(val[15:0]));
      REG_HYST:     hyst_cfg = val[11:0];
      REG_AMP:      amp_cfg = val[13:0];
      REG_TLIMIT:   tlim_cfg = val;
      REG_SETTLE:   settle_cfg = val;
      REG_CYCLES:   creq_cfg = val[7:0];
      REG_RULE:     rule_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input int sp, input int hy, input int amp, input logic [31:0] tl,
                         input logic [31:0] st, input int cr, input int ru);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_HYST, hy);
    write_reg(REG_AMP, amp);
    write_reg(REG_TLIMIT, tl);
    write_reg(REG_SETTLE, st);
    write_reg(REG_CYCLES, cr);
    write_reg(REG_RULE, ru);
  endtask

  // a tuning run: begin, then a triangle wave around the setpoint
  task automatic tuning_run(input int n_samp);
    logic [31:0] t;
    int per, amp, k;
    longint v;
    tune_res_t dummy;
    dummy = '0;
    t = $urandom;
    per = $urandom_range(4, 12);
    amp = $urandom_range(20, 3000);
    send_item(CMD_BEGIN, 16'($urandom), t, 0, dummy);
    for (k = 0; k < n_samp; k++) begin
      t += $urandom_range(40, 500);
      v = sp_cfg + (amp * (((k % per) < per / 2) ? (k % per) : (per - k % per))) * 2 / per
          - amp / 2 + $signed($urandom_range(0, 20)) - 10;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if ($urandom_range(99) < 2)
        send_item(($urandom_range(1) ? CMD_NOP : CMD_CANCEL), 16'(v), t, 0, dummy);
      else
        send_item(CMD_SAMPLE, 16'(v), t, 0, dummy);
      if (!act_f) break;
    end
  endtask

  task automatic noise_item();
    tune_res_t dummy;
    dummy = '0;
    send_item(2'($urandom_range(3)), 16'($urandom), $urandom, 0, dummy);
  endtask

  // receiver and result checker
  always @(posedge clk) begin
    tune_res_t e, a;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
      if (out_ch.valid && out_ch.ready) begin
        a = '{out_ch.drive, out_ch.running, out_ch.finished, out_ch.tuned_ok,
              out_ch.gain_p_out, out_ch.gain_i_out, out_ch.gain_d_out};
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, a);
          n_err++;
        end else begin
          e = expected_q.pop_front();
          if (a.drive !== e.drive)
            $display("%0t: drive exp %0d act %0d", $time, e.drive, a.drive);
          if (a.running !== e.running)
            $display("%0t: running exp %0b act %0b", $time, e.running, a.running);
          if (a.finished !== e.finished)
            $display("%0t: finished exp %0b act %0b", $time, e.finished, a.finished);
          if (a.tuned_ok !== e.tuned_ok)
            $display("%0t: tuned_ok exp %0b act %0b", $time, e.tuned_ok, a.tuned_ok);
          if (a.kp !== e.kp) $display("%0t: kp exp %h act %h", $time, e.kp, a.kp);
          if (a.ki !== e.ki) $display("%0t: ki exp %h act %h", $time, e.ki, a.ki);
          if (a.kd !== e.kd) $display("%0t: kd exp %h act %h", $time, e.kd, a.kd);
          if (a !== e) n_err++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      n_stall <= 0;
    end else if (n_stall >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", n_stall);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      n_stall <= n_stall + 1;
    end
  end

  initial begin
    stim_row_t dir_tab [$];
    int i, ph;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_SAMPLE;
    in_ch.temperature <= '0;
    in_ch.now_ms <= '0;
    tuner_reset();
    dir_tab = '{
      '{CMD_SAMPLE, 16'sd0, 32'd5, 1, '0},
      '{CMD_CANCEL, 16'sd0, 32'd6, 1, '{15'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_NOP, 16'sd0, 32'd7, 1, '{15'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_BEGIN, 16'sd0, 32'd0, 1, '{15'd17920, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_SAMPLE, 16'sh7FFF, 32'd0, 1, '{15'd7680, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_SAMPLE, 16'sh8000, 32'd100, 0, '0},
      '{CMD_SAMPLE, 16'sd40, 32'd700, 0, '0},
      '{CMD_NOP, 16'sd0, 32'd710, 0, '0},
      '{CMD_SAMPLE, -16'sd100, 32'd900, 0, '0},
      '{CMD_SAMPLE, 16'sd100, 32'd1500, 0, '0},
      '{CMD_SAMPLE, -16'sd100, 32'd1700, 0, '0},
      '{CMD_SAMPLE, 16'sd100, 32'd2300, 0, '0},
      '{CMD_BEGIN, 16'sd0, 32'hFFFF_FF00, 0, '0},
      '{CMD_SAMPLE, 16'sd33, 32'h0000_0100, 0, '0},
      '{CMD_CANCEL, 16'sd0, 32'd0, 1, '{15'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_BEGIN, 16'sd0, 32'd0, 0, '0},
      '{CMD_SAMPLE, 16'sd0, 32'd600001, 1, '{15'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}},
      '{CMD_BEGIN, 16'sd5, 32'd10, 0, '0},
      '{CMD_BEGIN, 16'sd5, 32'd20, 0, '0},
      '{CMD_CANCEL, 16'sd0, 32'hFFFF_FFFF, 0, '0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 13;
    rx_idle_pct = 87;
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].temp, dir_tab[i].t_ms,
                dir_tab[i].has_exp, dir_tab[i].exp_res);
    drain();

    // zero required cycles: first sample finalizes and fails
    write_reg(REG_CYCLES, 0);
    tuning_run(3);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      src_idle_pct = (ph < 3) ? 13 : (ph < 6) ? 87 : 0;
      rx_idle_pct = (ph < 3) ? 87 : (ph < 6) ? 13 : 0;
      case (ph)
        0: set_all(-32768, 4095, 12800, 32'hFFFF_FFFF, 0, 255, 1);
        1: set_all(32767, 0, 0, 0, 32'hFFFF_FFFF, 1, 0);
        2: set_all(0, 0, 12800, 32'hFFFF_FFFF, 0, 1, 0);
        default: set_all($urandom_range(0, 400) - 200, $urandom_range(0, 60),
                         $urandom_range(0, 12800), $urandom_range(3000, 200000),
                         $urandom_range(0, 1500), $urandom_range(1, 5), $urandom_range(1));
      endcase
      if (ph == 7) hold_cnt = 400;
      i = n_items;
      while (n_items - i < 190) begin
        if ($urandom_range(99) < 85) tuning_run($urandom_range(10, 60));
        else noise_item();
        if (ph == 4 && n_items - i > 90 && n_items - i < 100) begin
          drain();
          i = i - 10;
        end
      end
      drain();
    end

    repeat (600) @(posedge clk);
    $display("Ran %0d items, %0d results, %0d successful tuning runs,", n_items, n_results,
             n_ok_runs);
    $display("over extreme and random settings, both gain rules and three idle patterns.");
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
